// ----- hdl/gaa_pkg.sv -----
// Shared constants and types for the gravity acceleration accumulator.
// No dependencies; imported by the top level.
package gaa_pkg;

   localparam int FIELD_W    = 40;  // width of position ports
   localparam int MU_W       = 40;  // width of the gravitational parameter
   localparam int SUM_W      = 64;  // accumulator and result width
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   // register index, taken from paddr[3]
   localparam logic REG_MIN_DIST_SQ = 1'b0;

   localparam logic [SUM_W-1:0] MIN_DIST_SQ_RESET = 64'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_CHECK,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DEN_GO,
      ST_DEN_WAIT,
      ST_NUM_GO,
      ST_NUM_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SAT,
      ST_DONE
   } gaa_state_type;

endpackage

// ----- hdl/gaa_mul.sv -----
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// Standalone; used by the top level for squares, the denominator and mu terms.
module gaa_mul #(
   parameter int A_W = 8,
   parameter int B_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   a,
   input  logic [B_W-1:0]   b,
   output logic             done,
   output logic [A_W+B_W-1:0] prod
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic [P_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [P_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = P_W'(a);
         b_in    = b;
         prod_in = '0;
         cnt_in  = CNT_W'(B_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (b_ff[0]) begin
            prod_in = prod_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

// ----- hdl/gaa_sqrt.sv -----
// Digit-by-digit integer square root: two radicand bits per cycle.
// Standalone; used by the top level to form floor(sqrt(distSq)).
module gaa_sqrt #(
   parameter int R_W = 82
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [R_W-1:0]     radicand,
   output logic               done,
   output logic [R_W/2-1:0]   root
);

   localparam int RT_W  = R_W / 2;
   localparam int REM_W = RT_W + 2;
   localparam int SH_W  = RT_W + 4;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [R_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [SH_W-1:0]  rem_sh;
   logic [SH_W-1:0]  trial;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[R_W-1:R_W-2]};
      trial   = SH_W'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RT_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- hdl/gaa_div.sv -----
// Restoring long divider: one quotient bit per cycle.
// Standalone; used by the top level for the per-component force quotient.
module gaa_div #(
   parameter int N_W = 112,
   parameter int D_W = 123
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] numer,
   input  logic [D_W-1:0] denom,
   output logic           done,
   output logic [N_W-1:0] quot
);

   localparam int CNT_W = $clog2(N_W + 1);

   // dividend shifts out the top while quotient bits shift in at the bottom
   logic [N_W-1:0]   nq_ff, nq_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [D_W:0]     rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, nq_ff[N_W-1]};
      ge      = rem_sh >= {1'b0, d_ff};
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         nq_in  = numer;
         rem_in = '0;
         d_in   = denom;
         cnt_in = CNT_W'(N_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = D_W'(rem_sh - {1'b0, d_ff});
         end else begin
            rem_in = D_W'(rem_sh);
         end
         nq_in  = {nq_ff[N_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = nq_ff;

endmodule

// ----- hdl/gravity_acceleration_accumulator.sv -----
// Pairwise gravity acceleration accumulator, top level.
// Depends on gaa_pkg, gaa_mul, gaa_sqrt and gaa_div.
//
// Usage:
//   req_* carries one transaction per body pair: target and source position,
//   the source's mu and a clear flag. rsp_* returns one transaction per
//   request: the saturating running sum of (dp*mu*2^FRAC_BITS)/(dist*distSq)
//   and a flag telling that the pair was closer than min_dist_sq (or
//   coincident) and was left out. The APB port holds min_dist_sq at
//   address 0 (64-bit data); the user must write it only while the block
//   is idle, which the block itself does not enforce. One transaction is
//   worked at a time; req_ready is high only in idle.
//   A transaction works through the squared distance (three squares on
//   the serial multiplier), the threshold check, the square root, the
//   denominator product, then per component a mu product, a serial
//   division and a saturating add, and last the load of the output
//   register; a skipped pair goes from the threshold check straight to
//   that load. The next request can be taken in the cycle after the
//   output register loads. The divider, one quotient bit per cycle,
//   takes the largest share of a transaction's time.
//   Reset zeroes the sums, sets min_dist_sq to one and drops any pending
//   result. While the receiver stalls the result holds in the output
//   register; a new request is taken meanwhile, and its result waits in
//   the finishing step until the output register frees up.
module gravity_acceleration_accumulator
   import gaa_pkg::*;
#(
   parameter int POS_BITS  = 40,
   parameter int FRAC_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [FIELD_W-1:0]     req_target_x,
   input  logic signed [FIELD_W-1:0]     req_target_y,
   input  logic signed [FIELD_W-1:0]     req_target_z,
   input  logic signed [FIELD_W-1:0]     req_source_x,
   input  logic signed [FIELD_W-1:0]     req_source_y,
   input  logic signed [FIELD_W-1:0]     req_source_z,
   input  logic        [MU_W-1:0]        req_source_mu,
   input  logic                          req_clear_sum,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SUM_W-1:0]       rsp_sum_x,
   output logic signed [SUM_W-1:0]       rsp_sum_y,
   output logic signed [SUM_W-1:0]       rsp_sum_z,
   output logic                          rsp_pair_skipped,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   localparam int P       = POS_BITS;
   localparam int EXT_W   = (P > FIELD_W) ? P : FIELD_W;
   localparam int SQ_W    = 2 * P;            // one squared component
   localparam int DSQ_W   = 2 * P + 2;        // sum of three squares
   localparam int DIST_W  = P + 1;            // floor(sqrt(distSq))
   localparam int DEN_W   = DIST_W + DSQ_W;   // dist * distSq
   localparam int PROD_W  = P + MU_W;         // |dp| * mu
   localparam int NUM_W   = PROD_W + FRAC_BITS;
   localparam int Q_W     = (NUM_W > SUM_W) ? NUM_W : SUM_W;
   localparam int CMP_W   = (DSQ_W > SUM_W) ? DSQ_W : SUM_W;
   localparam logic [SUM_W-1:0] SIGN = {1'b1, {(SUM_W-1){1'b0}}};

   // saturating add of a sign/magnitude term, done on offset-binary values
   function automatic logic [SUM_W-1:0] sat_add(
      input logic [SUM_W-1:0] acc,
      input logic             neg,
      input logic             ovf,
      input logic [SUM_W-1:0] m
   );
      logic [SUM_W-1:0] b;
      logic [SUM_W:0]   s;
      b = acc ^ SIGN;
      s = {1'b0, b} + {1'b0, m};
      if (ovf) begin
         b = neg ? '0 : '1;
      end else if (neg) begin
         b = (m > b) ? '0 : b - m;
      end else begin
         b = s[SUM_W] ? '1 : s[SUM_W-1:0];
      end
      return b ^ SIGN;
   endfunction

   gaa_state_type state_ff, state_in;

   logic [SUM_W-1:0] min_ff, min_in;
   logic [SUM_W-1:0] acc_ff [3];
   logic [SUM_W-1:0] acc_in [3];
   logic [P-1:0]     mag_ff [3];
   logic [P-1:0]     mag_in [3];
   logic [2:0]       neg_ff, neg_in;
   logic [MU_W-1:0]  mu_ff, mu_in;
   logic [DSQ_W-1:0] dsq_ff, dsq_in;
   logic [1:0]       k_ff, k_in;
   logic             skip_ff, skip_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_x_ff, rsp_x_in;
   logic [SUM_W-1:0] rsp_y_ff, rsp_y_in;
   logic [SUM_W-1:0] rsp_z_ff, rsp_z_in;
   logic             rsp_skip_ff, rsp_skip_in;

   // unit handshakes
   logic              sq_start, sq_done;
   logic [SQ_W-1:0]   sq_prod;
   logic              rt_start, rt_done;
   logic [DIST_W-1:0] rt_root;
   logic              den_start, den_done;
   logic [DEN_W-1:0]  den_prod;
   logic              num_start, num_done;
   logic [PROD_W-1:0] num_prod;
   logic              div_start, div_done;
   logic [NUM_W-1:0]  div_numer;
   logic [NUM_W-1:0]  div_quot;

   logic signed [EXT_W-1:0] tgt_ext [3];
   logic signed [EXT_W-1:0] src_ext [3];
   logic signed [P:0]       diff    [3];
   logic [P-1:0]            mag_sel;
   logic [Q_W-1:0]          q_ext;
   logic                    q_ovf;
   logic                    csr_wr;
   logic [CMP_W-1:0]        dsq_cmp;
   logic [CMP_W-1:0]        min_cmp;

   // position differences; low POS_BITS of each field as two's complement
   always_comb begin
      tgt_ext[0] = EXT_W'(req_target_x);
      tgt_ext[1] = EXT_W'(req_target_y);
      tgt_ext[2] = EXT_W'(req_target_z);
      src_ext[0] = EXT_W'(req_source_x);
      src_ext[1] = EXT_W'(req_source_y);
      src_ext[2] = EXT_W'(req_source_z);
      for (int i = 0; i < 3; i++) begin
         diff[i] = signed'({src_ext[i][P-1], src_ext[i][P-1:0]})
                 - signed'({tgt_ext[i][P-1], tgt_ext[i][P-1:0]});
      end
   end

   assign csr_wr    = psel && penable && pwrite;
   assign mag_sel   = mag_ff[k_ff];
   assign div_numer = NUM_W'(num_prod) << FRAC_BITS;
   assign q_ext     = Q_W'(div_quot);
   assign q_ovf     = (q_ext >> SUM_W) != '0;
   assign dsq_cmp   = CMP_W'(dsq_ff);
   assign min_cmp   = CMP_W'(min_ff);

   // serial units
   gaa_mul #(.A_W(P), .B_W(P)) u_sq_mul (
      .clock (clock), .reset (reset), .start (sq_start),
      .a (mag_sel), .b (mag_sel), .done (sq_done), .prod (sq_prod)
   );

   gaa_sqrt #(.R_W(DSQ_W)) u_sqrt (
      .clock (clock), .reset (reset), .start (rt_start),
      .radicand (dsq_ff), .done (rt_done), .root (rt_root)
   );

   gaa_mul #(.A_W(DSQ_W), .B_W(DIST_W)) u_den_mul (
      .clock (clock), .reset (reset), .start (den_start),
      .a (dsq_ff), .b (rt_root), .done (den_done), .prod (den_prod)
   );

   gaa_mul #(.A_W(P), .B_W(MU_W)) u_num_mul (
      .clock (clock), .reset (reset), .start (num_start),
      .a (mag_sel), .b (mu_ff), .done (num_done), .prod (num_prod)
   );

   gaa_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (div_numer), .denom (den_prod), .done (div_done), .quot (div_quot)
   );

   // sequencer: next state, datapath loads and unit starts
   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mu_in        = mu_ff;
      dsq_in       = dsq_ff;
      k_in         = k_ff;
      skip_in      = skip_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_skip_in  = rsp_skip_ff;
      req_ready    = 1'b0;
      sq_start     = 1'b0;
      rt_start     = 1'b0;
      den_start    = 1'b0;
      num_start    = 1'b0;
      div_start    = 1'b0;

      // retire the output once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr && paddr[3] == REG_MIN_DIST_SQ) begin
         min_in = pwdata;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = diff[i][P];
                  mag_in[i] = diff[i][P] ? P'(-diff[i]) : diff[i][P-1:0];
                  if (req_clear_sum) begin
                     acc_in[i] = '0;
                  end
               end
               mu_in    = req_source_mu;
               dsq_in   = '0;
               k_in     = '0;
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            sq_start = 1'b1;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (sq_done) begin
               dsq_in = dsq_ff + DSQ_W'(sq_prod);
               if (k_ff == 2'd2) begin
                  state_in = ST_CHECK;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_SQ_GO;
               end
            end
         end
         ST_CHECK: begin
            // coincident bodies are always skipped
            skip_in  = (dsq_ff == '0) || (dsq_cmp < min_cmp);
            k_in     = '0;
            state_in = ((dsq_ff == '0) || (dsq_cmp < min_cmp)) ? ST_DONE : ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            rt_start = 1'b1;
            state_in = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (rt_done) begin
               state_in = ST_DEN_GO;
            end
         end
         ST_DEN_GO: begin
            den_start = 1'b1;
            state_in  = ST_DEN_WAIT;
         end
         ST_DEN_WAIT: begin
            if (den_done) begin
               state_in = ST_NUM_GO;
            end
         end
         ST_NUM_GO: begin
            num_start = 1'b1;
            state_in  = ST_NUM_WAIT;
         end
         ST_NUM_WAIT: begin
            if (num_done) begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            acc_in[k_ff] = sat_add(acc_ff[k_ff], neg_ff[k_ff], q_ovf,
                                   q_ext[SUM_W-1:0]);
            if (k_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_NUM_GO;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = acc_ff[0];
               rsp_y_in     = acc_ff[1];
               rsp_z_in     = acc_ff[2];
               rsp_skip_in  = skip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_DIST_SQ_RESET;
         acc_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      mu_ff       <= mu_in;
      dsq_ff      <= dsq_in;
      skip_ff     <= skip_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_skip_ff <= rsp_skip_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sum_x        = rsp_x_ff;
   assign rsp_sum_y        = rsp_y_ff;
   assign rsp_sum_z        = rsp_z_ff;
   assign rsp_pair_skipped = rsp_skip_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[3] == REG_MIN_DIST_SQ) ? min_ff : '0;

endmodule
